### sv/spq_pkg.sv
// shared types, codes and defaults of the sorted priority queue
package spq_pkg;

  localparam int unsigned DepthDefault         = 16;
  localparam int unsigned ValueWidthDefault    = 32;
  localparam int unsigned PriorityWidthDefault = 16;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] new_value;
    logic signed [15:0] new_priority;
  } spq_req_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic               is_empty;
    logic        [4:0]  entry_count;
    logic        [1:0]  status;
  } spq_rsp_t;

  // operation applied to every cell in the same cycle
  typedef struct packed {
    logic push;
    logic pop;
  } spq_op_t;

endpackage

### sv/spq_cell.sv
// one compare-and-shift cell of the sorted row
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned ValueWidth    = ValueWidthDefault,
  parameter int unsigned PriorityWidth = PriorityWidthDefault
) (
  input  logic                            clk_i,
  input  spq_op_t                         op_i,
  input  logic                            occupied_i,
  input  logic signed [ValueWidth-1:0]    new_value_i,
  input  logic signed [PriorityWidth-1:0] new_priority_i,
  input  logic                            left_ge_i,
  input  logic signed [ValueWidth-1:0]    left_value_i,
  input  logic signed [PriorityWidth-1:0] left_priority_i,
  input  logic signed [ValueWidth-1:0]    right_value_i,
  input  logic signed [PriorityWidth-1:0] right_priority_i,
  output logic                            ge_o,
  output logic signed [ValueWidth-1:0]    value_o,
  output logic signed [PriorityWidth-1:0] priority_o,
  output logic signed [ValueWidth-1:0]    value_d_o
);

  logic signed [ValueWidth-1:0]    value_q, value_d;
  logic signed [PriorityWidth-1:0] priority_q, priority_d;

  // new entry belongs at or in front of this cell; empty cells always agree
  assign ge_o = !occupied_i || (priority_q <= new_priority_i);

  always_comb begin
    value_d    = value_q;
    priority_d = priority_q;
    if (op_i.push) begin
      if (ge_o && !left_ge_i) begin
        value_d    = new_value_i;
        priority_d = new_priority_i;
      end else if (ge_o) begin
        value_d    = left_value_i;
        priority_d = left_priority_i;
      end
    end else if (op_i.pop) begin
      value_d    = right_value_i;
      priority_d = right_priority_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    priority_q <= priority_d;
  end

  assign value_o    = value_q;
  assign priority_o = priority_q;
  assign value_d_o  = value_d;

endmodule

### sv/sorted_priority_queue_top.sv
// sorted priority queue built as a row of compare-and-shift cells
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_i  (spq_req_t)
//   result    out        done_o strobe        rsp_o  (spq_rsp_t)
//
// one transfer per cycle: every cell compares and shifts in the same cycle,
// so a push or pop finishes in the cycle it is taken
// the result is registered and appears on rsp_o in the cycle after the transfer,
// marked by done_o; busy stays low; the request side is never held off
// reset clears the fill count and the result strobe; cell contents are
// left as they are and never show, since only filled cells are read
// the receiver cannot stall, so no result is ever held back
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned Depth         = DepthDefault,
  parameter int unsigned ValueWidth    = ValueWidthDefault,
  parameter int unsigned PriorityWidth = PriorityWidthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_req_t req_i,
  output logic     done_o,
  output spq_rsp_t rsp_o
);

  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [CntWidth-1:0] count_q, count_d;
  logic                done_q;
  spq_rsp_t            rsp_q, rsp_d;

  logic    accept;
  logic    full, empty;
  spq_op_t op;

  logic signed [ValueWidth-1:0]    new_value;
  logic signed [PriorityWidth-1:0] new_priority;

  // per-cell wiring of the row
  logic                            occupied [Depth];
  logic                            ge       [Depth];
  logic signed [ValueWidth-1:0]    value    [Depth];
  logic signed [PriorityWidth-1:0] prio     [Depth];
  logic signed [ValueWidth-1:0]    value_d  [Depth];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntWidth'(Depth));
  assign empty  = (count_q == '0);

  // fit the incoming fields to the stored widths, sign kept
  assign new_value    = ValueWidth'(req_i.new_value);
  assign new_priority = PriorityWidth'(req_i.new_priority);

  assign op.push = accept && (req_i.req_type == REQ_PUSH) && !full;
  assign op.pop  = accept && (req_i.req_type == REQ_POP) && !empty;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                            left_ge;
    logic signed [ValueWidth-1:0]    left_value, right_value;
    logic signed [PriorityWidth-1:0] left_prio, right_prio;

    assign occupied[i] = (count_q > CntWidth'(i));

    if (i == 0) begin : g_head
      // nothing in front of the head cell
      assign left_ge    = 1'b0;
      assign left_value = new_value;
      assign left_prio  = new_priority;
    end else begin : g_body
      assign left_ge    = ge[i-1];
      assign left_value = value[i-1];
      assign left_prio  = prio[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      // last cell keeps its own contents on pop, it is vacated by the count
      assign right_value = value[i];
      assign right_prio  = prio[i];
    end else begin : g_inner
      assign right_value = value[i+1];
      assign right_prio  = prio[i+1];
    end

    spq_cell #(
      .ValueWidth   (ValueWidth),
      .PriorityWidth(PriorityWidth)
    ) u_cell (
      .clk_i           (clk_i),
      .op_i            (op),
      .occupied_i      (occupied[i]),
      .new_value_i     (new_value),
      .new_priority_i  (new_priority),
      .left_ge_i       (left_ge),
      .left_value_i    (left_value),
      .left_priority_i (left_prio),
      .right_value_i   (right_value),
      .right_priority_i(right_prio),
      .ge_o            (ge[i]),
      .value_o         (value[i]),
      .priority_o      (prio[i]),
      .value_d_o       (value_d[i])
    );
  end

  // fill count and result of the current transfer
  always_comb begin
    count_d = count_q;
    if (op.push) begin
      count_d = count_q + 1'b1;
    end else if (op.pop) begin
      count_d = count_q - 1'b1;
    end

    rsp_d              = '0;
    rsp_d.popped_value = op.pop ? 32'(value[0]) : '0;
    rsp_d.top_value    = (count_d != '0) ? 32'(value_d[0]) : '0;
    rsp_d.is_empty     = (count_d == '0);
    rsp_d.entry_count  = 5'(count_d);
    rsp_d.status       = ST_OK;
    if (req_i.req_type == REQ_PUSH && full) begin
      rsp_d.status = ST_PUSH_FULL;
    end else if (req_i.req_type == REQ_POP && empty) begin
      rsp_d.status = ST_POP_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload, qualified by the strobe
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### sv/spq_checker.sv
// port-level checks of the sorted priority queue, bound to the top level
module spq_checker
  import spq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input spq_req_t req_i,
  input logic     done_o,
  input spq_rsp_t rsp_o
);

  // every transfer gives exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after a request transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a request transfer");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.is_empty) |->
      (rsp_o.entry_count == '0 && rsp_o.top_value == '0))
    else $error("empty queue reports entries or a top value");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_POP_EMPTY) |->
      (rsp_o.popped_value == '0 && rsp_o.is_empty))
    else $error("pop on empty returned data or a non-empty queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && rsp_o.status == ST_OK
      && $past(req_i.req_type == REQ_POP, 1)) |->
      (rsp_o.entry_count == $past(rsp_o.entry_count) - 5'd1))
    else $error("successful pop did not lower the count by one");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
